// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Every checker samples on clk and is
// disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every sampled edge.
`define RCO_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The condition must never be true at a sampled edge.
`define RCO_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/rco_pkg.sv =====
`timescale 1ns / 1ps

package rco_pkg;

  localparam int MAX_PIECE_DEF = 16;
  localparam int MAX_ROD_DEF   = 64;

  localparam int REV_W   = 22;
  localparam int CUT_W   = 5;
  localparam int PRICE_W = 16;
  localparam int PLEN_W  = 5;
  localparam int ROD_W   = 7;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_SOLVE = 1'b1;

  typedef struct packed {
    logic               op;
    logic [PLEN_W-1:0]  piece_length;
    logic [PRICE_W-1:0] price;
    logic [ROD_W-1:0]   rod_length;
  } in_t;

  typedef struct packed {
    logic [REV_W-1:0] best_revenue;
    logic [CUT_W-1:0] cut_length;
    logic             last_piece;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ZERO,
    S_FILL,
    S_DRAIN,
    S_WB,
    S_WALK_RD,
    S_WALK_OUT
  } state_t;

endpackage

// ===== hw/rtl/rod_cutting_optimizer.sv =====
`timescale 1ns / 1ps
// Rod cutting optimizer. A load request (op 0) writes the price of one piece
// length; lengths of 0 or above MAX_PIECE are dropped. A solve request (op 1)
// fills the best-revenue and first-cut tables for lengths 1 to n (rod_length,
// saturated to MAX_ROD), then walks the plan and returns one result per piece,
// left to right, each with the total revenue and the final one marked. A rod
// of length zero returns a single result with piece 0; a remainder with no
// profitable cut ends the plan with piece 0. The fill is bound by the single
// read port of the table memory: length j reads the candidates for first cuts
// 1 to min(j, MAX_PIECE) one after another, then drains the last read and
// writes its entry back, and each result is a table read followed by an
// output step. Input is stalled during a solve; the output register lets the
// next request in while the last result is still waiting.

`include "assert_macros.svh"

module rod_cutting_optimizer import rco_pkg::*; #(
  parameter int MAX_PIECE = MAX_PIECE_DEF,
  parameter int MAX_ROD   = MAX_ROD_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int RW = $clog2(MAX_ROD + 1);
  localparam int PW = $clog2(MAX_PIECE + 1);

  state_t state_r, state_nxt;

  logic [RW-1:0]    n_r, n_nxt;
  logic [RW-1:0]    j_r, j_nxt;
  logic [RW-1:0]    i_r, i_nxt;
  logic [RW-1:0]    left_r, left_nxt;
  logic [RW-1:0]    cnt_r, cnt_nxt;
  logic [REV_W:0]   best_r, best_nxt;
  logic [PW-1:0]    cut_r, cut_nxt;
  logic [REV_W-1:0] total_r, total_nxt;
  logic             rd_pend_r, rd_pend_nxt;
  logic             rd_zero_r, rd_zero_nxt;
  logic [PW-1:0]    rd_i_r, rd_i_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_r, out_nxt;

  logic               in_acc;
  logic               out_free;
  logic               out_load;
  logic [RW-1:0]      n_in;
  logic [RW-1:0]      m_lim;
  logic [7:0]         rod8;
  logic [7:0]         plen8;
  logic [7:0]         i8;
  logic [7:0]         j8;
  logic [7:0]         cut8;
  logic [7:0]         left8;
  logic [7:0]         rest8;
  logic [REV_W:0]     cand;
  logic               walk_last;

  logic               pr_we;
  logic [PW-1:0]      pr_waddr;
  logic               pr_re;
  logic [PW-1:0]      pr_raddr;
  logic [PRICE_W-1:0] pr_rdata;

  logic               dp_we;
  logic               dp_re;
  logic [RW-1:0]      dp_raddr;
  logic [REV_W-1:0]   dp_rbest;
  logic [PW-1:0]      dp_rcut;

  rco_price_mem #(.MAX_PIECE(MAX_PIECE)) u_price (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (pr_we),
    .waddr (pr_waddr),
    .wdata (in_data.price),
    .re    (pr_re),
    .raddr (pr_raddr),
    .rdata (pr_rdata)
  );

  rco_dp_mem #(.MAX_ROD(MAX_ROD), .MAX_PIECE(MAX_PIECE)) u_dp (
    .clk   (clk),
    .we    (dp_we),
    .waddr (j_r),
    .wbest (best_r[REV_W-1:0]),
    .wcut  (cut_r),
    .re    (dp_re),
    .raddr (dp_raddr),
    .rbest (dp_rbest),
    .rcut  (dp_rcut)
  );

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign rod8  = 8'(in_data.rod_length);
  assign n_in  = (rod8 > 8'(MAX_ROD)) ? RW'(MAX_ROD) : rod8[RW-1:0];
  assign plen8 = 8'(in_data.piece_length);

  assign pr_we    = in_acc && (in_data.op == OP_LOAD) && (plen8 != 8'd0) &&
                    (plen8 <= 8'(MAX_PIECE));
  assign pr_waddr = plen8[PW-1:0];

  // The inner loop stops at the shorter of the rod so far and the longest piece.
  assign j8    = 8'(j_r);
  assign m_lim = (j8 < 8'(MAX_PIECE)) ? j_r : RW'(MAX_PIECE);
  assign i8    = 8'(i_r);
  assign pr_raddr = i8[PW-1:0];

  // Entry 0 of the best table is zero by definition; it is never written and its read value is ignored.
  assign cand = (REV_W + 1)'(pr_rdata) + (rd_zero_r ? '0 : (REV_W + 1)'(dp_rbest));

  assign cut8      = 8'(dp_rcut);
  assign left8     = 8'(left_r);
  assign rest8     = left8 - cut8;
  assign walk_last = (dp_rcut == '0) || (cut8 >= left8) || (cnt_r == RW'(MAX_ROD - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_data.op == OP_SOLVE)) begin
          state_nxt = (n_in == '0) ? S_ZERO : S_FILL;
        end
      end
      S_ZERO: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_FILL: begin
        if (i_r == m_lim) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_WB;
      end
      S_WB: begin
        state_nxt = (j_r == n_r) ? S_WALK_RD : S_FILL;
      end
      S_WALK_RD: begin
        state_nxt = S_WALK_OUT;
      end
      S_WALK_OUT: begin
        if (out_free) begin
          state_nxt = walk_last ? S_IDLE : S_WALK_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall    = (state_r != S_IDLE);
    pr_re       = 1'b0;
    dp_we       = 1'b0;
    dp_re       = 1'b0;
    dp_raddr    = left_r;
    out_load    = 1'b0;
    out_nxt     = out_r;
    n_nxt       = n_r;
    j_nxt       = j_r;
    i_nxt       = i_r;
    left_nxt    = left_r;
    cnt_nxt     = cnt_r;
    best_nxt    = best_r;
    cut_nxt     = cut_r;
    total_nxt   = total_r;
    rd_pend_nxt = 1'b0;
    rd_zero_nxt = rd_zero_r;
    rd_i_nxt    = rd_i_r;

    // A candidate replaces the running best only when strictly greater, which
    // keeps the shorter first cut on a tie.
    if (rd_pend_r && (cand > best_r)) begin
      best_nxt = cand;
      cut_nxt  = rd_i_r;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_data.op == OP_SOLVE)) begin
          n_nxt    = n_in;
          j_nxt    = RW'(1);
          i_nxt    = RW'(1);
          best_nxt = '0;
          cut_nxt  = '0;
        end
      end
      S_ZERO: begin
        if (out_free) begin
          out_load             = 1'b1;
          out_nxt.best_revenue = '0;
          out_nxt.cut_length   = '0;
          out_nxt.last_piece   = 1'b1;
        end
      end
      S_FILL: begin
        pr_re       = 1'b1;
        dp_re       = 1'b1;
        dp_raddr    = j_r - i_r;
        rd_pend_nxt = 1'b1;
        rd_zero_nxt = (j_r == i_r);
        rd_i_nxt    = pr_raddr;
        if (i_r != m_lim) begin
          i_nxt = i_r + RW'(1);
        end
      end
      S_DRAIN: begin
      end
      S_WB: begin
        // The write gets a state of its own, so the next length's first read
        // of this entry sees the new value.
        dp_we = 1'b1;
        if (j_r == n_r) begin
          total_nxt = best_r[REV_W-1:0];
          left_nxt  = n_r;
          cnt_nxt   = '0;
        end else begin
          j_nxt    = j_r + RW'(1);
          i_nxt    = RW'(1);
          best_nxt = '0;
          cut_nxt  = '0;
        end
      end
      S_WALK_RD: begin
        dp_re    = 1'b1;
        dp_raddr = left_r;
      end
      S_WALK_OUT: begin
        if (out_free) begin
          out_load             = 1'b1;
          out_nxt.best_revenue = total_r;
          out_nxt.cut_length   = cut8[CUT_W-1:0];
          out_nxt.last_piece   = walk_last;
          left_nxt             = rest8[RW-1:0];
          cnt_nxt              = cnt_r + RW'(1);
        end
      end
      default: begin
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    j_r       <= j_nxt;
    i_r       <= i_nxt;
    left_r    <= left_nxt;
    cnt_r     <= cnt_nxt;
    best_r    <= best_nxt;
    cut_r     <= cut_nxt;
    total_r   <= total_nxt;
    rd_zero_r <= rd_zero_nxt;
    rd_i_r    <= rd_i_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `RCO_ASSERT_NEVER(a_no_rw_overlap, dp_we && dp_re, "table read and write in the same cycle")
  `RCO_ASSERT(a_fill_below_j, (state_r == S_FILL) |-> (i_r != '0) && (i_r <= j_r), "fill reads an entry not yet solved")
  `RCO_ASSERT(a_walk_left, (state_r == S_WALK_OUT) |-> (left_r != '0), "plan walk with nothing left")
  `RCO_ASSERT(a_last_ends, (out_load && out_nxt.last_piece) |=> (state_r == S_IDLE), "solve continues after its final result")

endmodule

// ===== hw/rtl/rco_price_mem.sv =====
`timescale 1ns / 1ps

module rco_price_mem import rco_pkg::*; #(
  parameter int MAX_PIECE = MAX_PIECE_DEF,
  localparam int PW = $clog2(MAX_PIECE + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               we,
  input  logic [PW-1:0]      waddr,
  input  logic [PRICE_W-1:0] wdata,
  input  logic               re,
  input  logic [PW-1:0]      raddr,
  output logic [PRICE_W-1:0] rdata
);

  logic [PRICE_W-1:0] mem [MAX_PIECE+1];
  logic [MAX_PIECE:0] vld_r;
  logic [PRICE_W-1:0] q_r;
  logic               q_vld_r;

  // Entries that were never loaded since reset read as a zero price.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      q_r     <= mem[raddr];
      q_vld_r <= vld_r[raddr];
    end
  end

  assign rdata = q_vld_r ? q_r : '0;

endmodule

// ===== hw/rtl/rco_dp_mem.sv =====
`timescale 1ns / 1ps

module rco_dp_mem import rco_pkg::*; #(
  parameter int MAX_ROD   = MAX_ROD_DEF,
  parameter int MAX_PIECE = MAX_PIECE_DEF,
  localparam int RW = $clog2(MAX_ROD + 1),
  localparam int PW = $clog2(MAX_PIECE + 1)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [RW-1:0]    waddr,
  input  logic [REV_W-1:0] wbest,
  input  logic [PW-1:0]    wcut,
  input  logic             re,
  input  logic [RW-1:0]    raddr,
  output logic [REV_W-1:0] rbest,
  output logic [PW-1:0]    rcut
);

  // Best revenue and first cut share one word per rod length.
  logic [REV_W+PW-1:0] mem [MAX_ROD+1];
  logic [REV_W+PW-1:0] q_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wbest, wcut};
    end
    if (re) begin
      q_r <= mem[raddr];
    end
  end

  assign rbest = q_r[REV_W+PW-1:PW];
  assign rcut  = q_r[PW-1:0];

endmodule

// ===== tb/rco_checker.sv =====
`timescale 1ns / 1ps

module rco_checker import rco_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_stall,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_stall,
  input  out_t out_data,
  output int   fail_cnt,
  output int   pending
);

  localparam int MAXP = MAX_PIECE_DEF;
  localparam int MAXR = MAX_ROD_DEF;

  logic [PRICE_W-1:0] price_tab [0:MAXP];
  logic [REV_W-1:0]   best_rev  [0:MAXR];
  logic [CUT_W-1:0]   first_cut [0:MAXR];

  out_t plan_q[$];
  int   mismatches;

  // Loads update the price list; a solve fills both tables bottom up and
  // queues the cut plan it should return.
  function automatic void plan_rod(input in_t req);
    int   n;
    int   j;
    int   i;
    int   cand;
    int   best;
    int   cut;
    int   left;
    int   cnt;
    out_t res;
    logic [REV_W-1:0] total;
    if (req.op == OP_LOAD) begin
      if (req.piece_length >= 1 && req.piece_length <= MAXP) begin
        price_tab[req.piece_length] = req.price;
      end
      return;
    end
    n = (req.rod_length > MAXR) ? MAXR : int'(req.rod_length);
    best_rev[0] = '0;
    first_cut[0] = '0;
    for (j = 1; j <= n; j++) begin
      best = 0;
      cut = 0;
      for (i = 1; i <= j && i <= MAXP; i++) begin
        cand = int'(price_tab[i]) + int'(best_rev[j - i]);
        // Strictly greater, so a tie keeps the shorter first cut.
        if (cand > best) begin
          best = cand;
          cut = i;
        end
      end
      best_rev[j] = best[REV_W-1:0];
      first_cut[j] = cut[CUT_W-1:0];
    end
    total = best_rev[n];
    if (n == 0) begin
      res.best_revenue = '0;
      res.cut_length = '0;
      res.last_piece = 1'b1;
      plan_q.insert(plan_q.size(), res);
      return;
    end
    left = n;
    cnt = 0;
    while (left > 0 && cnt < MAXR) begin
      cut = first_cut[left];
      res.best_revenue = total;
      res.cut_length = cut[CUT_W-1:0];
      res.last_piece = 1'b0;
      plan_q.insert(plan_q.size(), res);
      cnt++;
      // A remainder without a profitable cut is left unsold.
      if (cut == 0 || cut > left) break;
      left -= cut;
    end
    plan_q[plan_q.size() - 1].last_piece = 1'b1;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      foreach (price_tab[k]) price_tab[k] = '0;
      plan_q.delete();
      mismatches = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (plan_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result: rev %0d cut %0d last %0d",
                     out_data.best_revenue, out_data.cut_length, out_data.last_piece);
          end
        end else begin
          want = plan_q.pop_front();
          if (out_data.best_revenue !== want.best_revenue ||
              out_data.cut_length !== want.cut_length ||
              out_data.last_piece !== want.last_piece) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected rev %0d cut %0d last %0d, %s",
                       want.best_revenue, want.cut_length, want.last_piece,
                       $sformatf("got rev %0d cut %0d last %0d",
                                 out_data.best_revenue, out_data.cut_length,
                                 out_data.last_piece));
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        plan_rod(in_data);
      end
    end
    fail_cnt <= mismatches;
    pending <= plan_q.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import rco_pkg::*;

  localparam int RAND_ITEMS   = 200;
  localparam int HOLD_CYCLES  = 3000;
  localparam int DRAIN_CYCLES = 300;
  localparam int LIMIT        = 2000000;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  int fail_cnt;
  int pending;
  int cycle_cnt = 0;
  int burst_left;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  bit draining = 1'b0;

  always #1 clk = ~clk;

  rod_cutting_optimizer u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  rco_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .fail_cnt (fail_cnt),
    .pending  (pending)
  );

  // Fields a request ignores are filled with random values.
  function automatic in_t mk_load(input int len, input int price);
    in_t r;
    r.op = OP_LOAD;
    r.piece_length = len[PLEN_W-1:0];
    r.price = price[PRICE_W-1:0];
    r.rod_length = ROD_W'($urandom_range(0, 127));
    return r;
  endfunction

  function automatic in_t mk_solve(input int rod);
    in_t r;
    r.op = OP_SOLVE;
    r.piece_length = PLEN_W'($urandom_range(0, 31));
    r.price = PRICE_W'($urandom);
    r.rod_length = rod[ROD_W-1:0];
    return r;
  endfunction

  function automatic in_t rand_req();
    in_t r;
    int  pick;
    r.op = ($urandom_range(0, 99) < 55) ? OP_LOAD : OP_SOLVE;
    if ($urandom_range(0, 9) < 8) r.piece_length = PLEN_W'($urandom_range(1, MAX_PIECE_DEF));
    else r.piece_length = PLEN_W'($urandom_range(0, 31));
    case ($urandom_range(0, 3))
      0: r.price = '0;
      1: r.price = PRICE_W'($urandom_range(0, 40));
      default: r.price = PRICE_W'($urandom);
    endcase
    // Most rods are short so the fill stays cheap; a few go past the maximum.
    pick = $urandom_range(0, 9);
    if (pick < 7) r.rod_length = ROD_W'($urandom_range(0, 16));
    else if (pick < 9) r.rod_length = ROD_W'($urandom_range(17, 64));
    else r.rod_length = ROD_W'($urandom_range(65, 127));
    return r;
  endfunction

  task automatic issue(input in_t r);
    int gap;
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin : stim
    int prices [1:10] = '{1, 5, 8, 9, 10, 17, 17, 20, 24, 30};
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    burst_left = $urandom_range(1, 8);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue(mk_solve(0));
    issue(mk_solve(5));
    // Only length 3 sells, so a rod of 5 is planned as cuts 1, 1 and 3, the zero-price pieces first.
    issue(mk_load(3, 7));
    issue(mk_solve(5));
    for (int k = 1; k <= 10; k++) issue(mk_load(k, prices[k]));
    issue(mk_load(0, 999));
    issue(mk_load(17, 12345));
    issue(mk_load(31, 65535));
    issue(mk_solve(4));
    issue(mk_solve(10));
    issue(mk_solve(127));
    issue(mk_load(16, 65535));
    issue(mk_load(1, 65535));
    issue(mk_solve(64));
    issue(mk_solve(100));

    hold_go = 1'b1;
    repeat (RAND_ITEMS) issue(rand_req());
    in_valid <= 1'b0;

    // The pending count is registered, so it lags the accepting edge.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    draining = 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && pending == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin : rx_stall
    int span;
    int pct;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (draining) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (hold_go && !hold_done) begin
        // Long hold-off so the output backs up and the input stalls.
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        span = $urandom_range(10, 120);
        case ($urandom_range(0, 3))
          0: pct = 0;
          1: pct = 25;
          2: pct = 50;
          default: pct = 85;
        endcase
        repeat (span) begin
          out_stall <= ($urandom_range(0, 99) < pct);
          @(posedge clk);
          if (draining || (hold_go && !hold_done)) break;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

endmodule
